FILE: sv/bee_pkg.sv
package bee_pkg;

  // word width of the evaluation arithmetic
  localparam int DATA_WIDTH = 32;
  localparam int ACC_WIDTH  = DATA_WIDTH - 1;
  localparam int OUT_WIDTH  = 32;

  // character codes
  localparam logic [7:0] CH_OR      = 8'h7C;
  localparam logic [7:0] CH_XOR     = 8'h5E;
  localparam logic [7:0] CH_AND     = 8'h26;
  localparam logic [7:0] CH_TILDE   = 8'h7E;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // bit positions of the pending level mask
  localparam int LV_AND = 0;
  localparam int LV_XOR = 1;
  localparam int LV_OR  = 2;

  typedef enum logic [2:0] {
    PH_OPERAND,
    PH_TILDE,
    PH_DIGIT,
    PH_NUMBER,
    PH_SKIP
  } phase_t;

  typedef enum logic [1:0] {
    UM_NONE,
    UM_NEG,
    UM_INV,
    UM_INVNEG
  } unary_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_START,
    ST_NO_DIGIT
  } status_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] value;
    status_t                     status;
  } result_t;

endpackage

FILE: sv/bee_if.sv
interface char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface result_if;
  logic                              valid;
  logic                              ready;
  logic signed [bee_pkg::OUT_WIDTH-1:0] value;
  logic [1:0]                        status;

  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

FILE: sv/bitwise_expression_evaluator.sv
// channel   dir  payload                          handshake
// chars     in   char_code[7:0]                   valid/ready
// results   out  value[31:0] signed, status[1:0]  valid/ready
//
// one character per cycle while chars.ready is high; the character that ends an expression
// or raises an error registers its result in the output register or the skid entry
// the per-character step (decimal accumulate with saturation, one bitwise merge
// per precedence level) sits between the state registers and the result register
// reset clears the parse state to expect an operand and empties the output stage
// chars.ready drops only while a result waits in the skid entry behind a stalled output
module bitwise_expression_evaluator (
  input  logic     clk,
  input  logic     rst,
  char_if.sink     chars,
  result_if.source results
);

  localparam int DW = bee_pkg::DATA_WIDTH;
  localparam int AW = bee_pkg::ACC_WIDTH;

  bee_pkg::phase_t phase, phase_next;
  bee_pkg::unary_t unary, unary_next;
  logic [AW-1:0]   acc, acc_next;
  logic [DW-1:0]   and_p, and_next;
  logic [DW-1:0]   xor_p, xor_next;
  logic [DW-1:0]   or_p, or_next;
  logic [2:0]      levels, levels_next;

  logic             accept;
  logic             space;
  logic             res_push;
  bee_pkg::result_t res_data;

  logic [7:0]    c;
  logic          is_digit;
  logic [3:0]    digit;
  logic [AW+3:0] prod;
  logic [AW-1:0] acc_step;
  logic [DW-1:0] accx;
  logic [DW-1:0] operand;
  logic [DW-1:0] and_m;
  logic [DW-1:0] xor_f;
  logic [DW-1:0] or_f;

  assign c        = chars.char_code;
  assign accept   = chars.valid && space;
  assign is_digit = (c >= bee_pkg::CH_0) && (c <= bee_pkg::CH_9);
  assign digit    = 4'(c - bee_pkg::CH_0);

  // acc * 10 + digit, saturating at the largest positive word
  assign prod     = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (AW+4)'(digit);
  assign acc_step = (prod > (AW+4)'({AW{1'b1}})) ? {AW{1'b1}} : prod[AW-1:0];

  // finished operand with its prefix applied
  assign accx = {1'b0, acc};
  always_comb begin
    case (unary)
      bee_pkg::UM_NEG:    operand = -accx;
      bee_pkg::UM_INV:    operand = ~accx;
      bee_pkg::UM_INVNEG: operand = accx - DW'(1);
      default:            operand = accx;
    endcase
  end

  // merges down the precedence levels
  assign and_m = levels[bee_pkg::LV_AND] ? (and_p & operand) : operand;
  assign xor_f = levels[bee_pkg::LV_XOR] ? (xor_p ^ and_m) : and_m;
  assign or_f  = levels[bee_pkg::LV_OR] ? (or_p | xor_f) : xor_f;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= bee_pkg::PH_OPERAND;
      unary  <= bee_pkg::UM_NONE;
      acc    <= '0;
      and_p  <= '0;
      xor_p  <= '0;
      or_p   <= '0;
      levels <= '0;
    end else if (accept) begin
      phase  <= phase_next;
      unary  <= unary_next;
      acc    <= acc_next;
      and_p  <= and_next;
      xor_p  <= xor_next;
      or_p   <= or_next;
      levels <= levels_next;
    end
  end

  // next state and result for one character
  always_comb begin
    phase_next  = phase;
    unary_next  = unary;
    acc_next    = acc;
    and_next    = and_p;
    xor_next    = xor_p;
    or_next     = or_p;
    levels_next = levels;
    res_push    = 1'b0;
    res_data    = '{value: '0, status: bee_pkg::ST_OK};

    unique case (phase)
      bee_pkg::PH_OPERAND: begin
        if (is_digit) begin
          acc_next   = AW'(digit);
          unary_next = bee_pkg::UM_NONE;
          phase_next = bee_pkg::PH_NUMBER;
        end else if (c == bee_pkg::CH_MINUS) begin
          unary_next = bee_pkg::UM_NEG;
          phase_next = bee_pkg::PH_DIGIT;
        end else if (c == bee_pkg::CH_TILDE) begin
          unary_next = bee_pkg::UM_INV;
          phase_next = bee_pkg::PH_TILDE;
        end else begin
          res_push        = 1'b1;
          res_data.status = bee_pkg::ST_BAD_START;
        end
      end
      bee_pkg::PH_TILDE: begin
        if (c == bee_pkg::CH_MINUS) begin
          unary_next = bee_pkg::UM_INVNEG;
          phase_next = bee_pkg::PH_DIGIT;
        end else if (is_digit) begin
          acc_next   = AW'(digit);
          phase_next = bee_pkg::PH_NUMBER;
        end else begin
          res_push        = 1'b1;
          res_data.status = bee_pkg::ST_NO_DIGIT;
        end
      end
      bee_pkg::PH_DIGIT: begin
        if (is_digit) begin
          acc_next   = AW'(digit);
          phase_next = bee_pkg::PH_NUMBER;
        end else begin
          res_push        = 1'b1;
          res_data.status = bee_pkg::ST_NO_DIGIT;
        end
      end
      bee_pkg::PH_NUMBER: begin
        if (is_digit) begin
          acc_next = acc_step;
        end else begin
          acc_next   = '0;
          unary_next = bee_pkg::UM_NONE;
          phase_next = bee_pkg::PH_OPERAND;
          if (c == bee_pkg::CH_AND) begin
            and_next    = and_m;
            levels_next = levels | 3'b001;
          end else if (c == bee_pkg::CH_XOR) begin
            and_next    = and_m;
            xor_next    = xor_f;
            levels_next = {levels[bee_pkg::LV_OR], 2'b10};
          end else if (c == bee_pkg::CH_OR) begin
            and_next    = and_m;
            xor_next    = xor_f;
            or_next     = or_f;
            levels_next = 3'b100;
          end else begin
            res_push       = 1'b1;
            res_data.value = bee_pkg::OUT_WIDTH'($signed(or_f));
          end
        end
      end
      default: begin
        // skipping the rest of a line
        if (c == bee_pkg::CH_NEWLINE) begin
          phase_next = bee_pkg::PH_OPERAND;
        end
      end
    endcase

    // a result or an error restarts; only a newline resumes at once
    if (res_push) begin
      acc_next    = '0;
      unary_next  = bee_pkg::UM_NONE;
      and_next    = '0;
      xor_next    = '0;
      or_next     = '0;
      levels_next = '0;
      phase_next  = (c == bee_pkg::CH_NEWLINE) ? bee_pkg::PH_OPERAND : bee_pkg::PH_SKIP;
    end
  end

  assign chars.ready = space;

  bee_out_buf u_out_buf (
    .clk     (clk),
    .rst     (rst),
    .push    (accept && res_push),
    .data    (res_data),
    .space   (space),
    .results (results)
  );

  // skipping means all partial results were cleared
  a_skip_clear: assert property (@(posedge clk) disable iff (rst)
    phase == bee_pkg::PH_SKIP |-> (levels == '0 && acc == '0))
    else $error("partial state left while skipping");

  // an operand start never carries a prefix
  a_operand_plain: assert property (@(posedge clk) disable iff (rst)
    phase == bee_pkg::PH_OPERAND |-> (unary == bee_pkg::UM_NONE && acc == '0))
    else $error("stale operand state at operand start");

  // after a tilde the prefix is plain invert
  a_tilde_mode: assert property (@(posedge clk) disable iff (rst)
    phase == bee_pkg::PH_TILDE |-> unary == bee_pkg::UM_INV)
    else $error("tilde phase with wrong prefix");

  // after a '|' fold only the or-level partial is pending
  a_levels_after_or: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == bee_pkg::PH_NUMBER && c == bee_pkg::CH_OR) |=> levels == 3'b100)
    else $error("or fold left lower levels pending");

endmodule

FILE: sv/bee_out_buf.sv
module bee_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bee_pkg::result_t data,
  output logic             space,
  result_if.source         results
);

  logic             out_valid;
  bee_pkg::result_t out_data;
  logic             skid_valid;
  bee_pkg::result_t skid_data;
  logic             take;

  assign take  = out_valid && results.ready;
  assign space = !skid_valid;

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_data  <= data;
        out_valid <= push;
      end
    end else if (push) begin
      skid_data  <= data;
      skid_valid <= 1'b1;
    end
  end

  assign results.valid  = out_valid;
  assign results.value  = out_data.value;
  assign results.status = out_data.status;

  // skid entry only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid with empty output register");

  // no push while the skid entry is occupied
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("result pushed with no space");

  // a stalled output keeps the skid entry
  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !results.ready) |=> skid_valid)
    else $error("skid entry lost under stall");

endmodule

FILE: test/expr_result_checker.sv
module expr_result_checker
  import bee_pkg::*;
(
  input  logic clk,
  input  logic rst,
  char_if      chars,
  result_if    results,
  output int   fail_count,
  output int   outstanding
);

  typedef logic [DATA_WIDTH-1:0] word_t;

  // largest magnitude a decimal operand may reach
  localparam word_t MAX_OPERAND = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  // parser state mirrored from the block
  phase_t     parse_phase;
  word_t      digits_acc;
  unary_t     prefix_mode;
  word_t      and_term;
  word_t      xor_term;
  word_t      or_term;
  logic [2:0] live_terms;

  // results still owed by the block, oldest first
  result_t    expected_results[$];
  result_t    oldest;

  task automatic clear_parser();
    parse_phase = PH_OPERAND;
    digits_acc  = '0;
    prefix_mode = UM_NONE;
    and_term    = '0;
    xor_term    = '0;
    or_term     = '0;
    live_terms  = '0;
  endtask

  task automatic push_result(input word_t w, input status_t s);
    result_t r;
    r.value  = $signed(w);
    r.status = s;
    expected_results.push_back(r);
  endtask

  // an error restarts at once on a newline, otherwise skips the line
  task automatic raise_error(input logic [7:0] c, input status_t s);
    push_result('0, s);
    clear_parser();
    if (c != CH_NEWLINE) parse_phase = PH_SKIP;
  endtask

  task automatic fold_and();
    if (live_terms[LV_AND]) begin
      xor_term = live_terms[LV_XOR] ? (xor_term ^ and_term) : and_term;
      live_terms[LV_AND] = 1'b0;
      live_terms[LV_XOR] = 1'b1;
    end
  endtask

  task automatic fold_xor();
    fold_and();
    if (live_terms[LV_XOR]) begin
      or_term = live_terms[LV_OR] ? (or_term | xor_term) : xor_term;
      live_terms[LV_XOR] = 1'b0;
      live_terms[LV_OR]  = 1'b1;
    end
  endtask

  // advance the expression parser by one character
  task automatic parse_char(input logic [7:0] c);
    logic  is_digit;
    word_t digit;
    word_t operand;
    is_digit = (c >= CH_0) && (c <= CH_9);
    digit    = word_t'(c - CH_0);
    case (parse_phase)
      PH_OPERAND: begin
        if (is_digit) begin
          digits_acc  = digit;
          prefix_mode = UM_NONE;
          parse_phase = PH_NUMBER;
        end else if (c == CH_MINUS) begin
          prefix_mode = UM_NEG;
          parse_phase = PH_DIGIT;
        end else if (c == CH_TILDE) begin
          prefix_mode = UM_INV;
          parse_phase = PH_TILDE;
        end else begin
          raise_error(c, ST_BAD_START);
        end
      end
      PH_TILDE: begin
        if (c == CH_MINUS) begin
          prefix_mode = UM_INVNEG;
          parse_phase = PH_DIGIT;
        end else if (is_digit) begin
          digits_acc  = digit;
          parse_phase = PH_NUMBER;
        end else begin
          raise_error(c, ST_NO_DIGIT);
        end
      end
      PH_DIGIT: begin
        if (is_digit) begin
          digits_acc  = digit;
          parse_phase = PH_NUMBER;
        end else begin
          raise_error(c, ST_NO_DIGIT);
        end
      end
      PH_NUMBER: begin
        if (is_digit) begin
          // saturate instead of overflowing
          if (digits_acc > (MAX_OPERAND - digit) / 10) digits_acc = MAX_OPERAND;
          else digits_acc = digits_acc * 10 + digit;
        end else begin
          case (prefix_mode)
            UM_NEG:    operand = -digits_acc;
            UM_INV:    operand = ~digits_acc;
            UM_INVNEG: operand = ~(-digits_acc);
            default:   operand = digits_acc;
          endcase
          and_term = live_terms[LV_AND] ? (and_term & operand) : operand;
          live_terms[LV_AND] = 1'b1;
          digits_acc  = '0;
          prefix_mode = UM_NONE;
          if (c == CH_AND) begin
            parse_phase = PH_OPERAND;
          end else if (c == CH_XOR) begin
            fold_and();
            parse_phase = PH_OPERAND;
          end else if (c == CH_OR) begin
            fold_xor();
            parse_phase = PH_OPERAND;
          end else begin
            // any other character ends the expression
            fold_xor();
            push_result(or_term, ST_OK);
            clear_parser();
            if (c != CH_NEWLINE) parse_phase = PH_SKIP;
          end
        end
      end
      default: begin
        if (c == CH_NEWLINE) clear_parser();
        else parse_phase = PH_SKIP;
      end
    endcase
  endtask

  // predict on accepted characters, compare on accepted results
  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (chars.valid && chars.ready) parse_char(chars.char_code);
      if (results.valid && results.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: value %0d status %0d", results.value, results.status);
          fail_count++;
        end else begin
          oldest = expected_results.pop_front();
          if (results.value !== oldest.value) begin
            $error("value: expected %0d, got %0d", oldest.value, results.value);
            fail_count++;
          end
          if (results.status !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, results.status);
            fail_count++;
          end
        end
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

FILE: test/tb_bitwise_expression_evaluator.sv
module tb_bitwise_expression_evaluator;
  import bee_pkg::*;

  logic clk;
  logic rst;
  int   fail_count;
  int   outstanding;
  int   chars_sent;
  int   ready_cycle;

  char_if   chars_bus();
  result_if results_bus();

  bitwise_expression_evaluator dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_bus),
    .results (results_bus)
  );

  expr_result_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .chars       (chars_bus),
    .results     (results_bus),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // offer one character, with random idle cycles outside the busy stretch
  task automatic send_char(input logic [7:0] c);
    while ((chars_sent < 1000 || chars_sent >= 1400) && $urandom_range(0, 99) < 25) begin
      chars_bus.valid <= 1'b0;
      @(posedge clk);
    end
    chars_bus.valid     <= 1'b1;
    chars_bus.char_code <= c;
    @(posedge clk);
    while (!chars_bus.ready) @(posedge clk);
    chars_sent++;
  endtask

  // stop offering and wait until every owed result has come out
  task automatic wait_drained();
    chars_bus.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // result side: random stalls, one long hold-off, one stretch with no stalls
  initial begin
    results_bus.ready <= 1'b0;
    ready_cycle = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        results_bus.ready <= 1'b0;
      end else begin
        ready_cycle++;
        if (ready_cycle >= 800 && ready_cycle < 900) results_bus.ready <= 1'b0;
        else if (ready_cycle >= 1600 && ready_cycle < 2000) results_bus.ready <= 1'b1;
        else results_bus.ready <= ($urandom_range(0, 99) >= 25);
      end
    end
  end

  // run limit
  initial begin
    #800000;
    $display("RESULT: ERROR");
    $finish;
  end

  // character stimulus
  initial begin
    string      directed;
    logic [7:0] line_chars[$];
    logic [7:0] term;
    int         kind;
    int         n_ops;
    int         n_digits;
    bit         paused;

    chars_bus.valid     <= 1'b0;
    chars_bus.char_code <= '0;
    rst                 <= 1'b1;
    chars_sent = 0;
    paused     = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // saturating inverted negation through all three operators, odd terminator
    directed = "~-9999999999&7^1|2x\n";
    foreach (directed[i]) send_char(directed[i]);
    // bad operand start on a newline, missing digit on a newline
    send_char(CH_NEWLINE);
    send_char(CH_MINUS);
    send_char(CH_NEWLINE);
    // missing digit after invert, then skip over extreme codes
    send_char(CH_TILDE);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CH_NEWLINE);
    wait_drained();

    // random lines: mostly expressions, some corrupted, some pure noise
    while (chars_sent < 1850) begin
      line_chars.delete();
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 6)) line_chars.push_back(8'($urandom_range(0, 255)));
        line_chars.push_back(CH_NEWLINE);
      end else begin
        n_ops = $urandom_range(1, 4);
        for (int k = 0; k < n_ops; k++) begin
          if (k != 0) begin
            case ($urandom_range(0, 2))
              0:       line_chars.push_back(CH_AND);
              1:       line_chars.push_back(CH_XOR);
              default: line_chars.push_back(CH_OR);
            endcase
          end
          case ($urandom_range(0, 3))
            1: line_chars.push_back(CH_MINUS);
            2: line_chars.push_back(CH_TILDE);
            3: begin
              line_chars.push_back(CH_TILDE);
              line_chars.push_back(CH_MINUS);
            end
            default: ;
          endcase
          n_digits = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 4);
          repeat (n_digits) line_chars.push_back(CH_0 + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 4) != 0) begin
          line_chars.push_back(CH_NEWLINE);
        end else begin
          // non-operator terminator followed by junk to skip
          do term = 8'($urandom_range(0, 255));
          while ((term >= CH_0 && term <= CH_9) || term == CH_AND || term == CH_XOR ||
                 term == CH_OR);
          line_chars.push_back(term);
          repeat ($urandom_range(0, 3)) line_chars.push_back(8'($urandom_range(0, 255)));
          line_chars.push_back(CH_NEWLINE);
        end
        if (kind <= 2)
          line_chars[$urandom_range(0, line_chars.size() - 1)] = 8'($urandom_range(0, 255));
      end
      foreach (line_chars[i]) send_char(line_chars[i]);

      // one pause until the block has handed back everything
      if (!paused && chars_sent > 1200) begin
        wait_drained();
        paused = 1'b1;
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
